@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands with the usual clock and reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define LRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be true out of reset
`define LRT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/lrt_pkg.sv @@
// ----------------------------------------------------------------------------
// lrt_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int COLOUR_BITS = 16;
    localparam int THICK_BITS  = 4;
    localparam int REG_INDEX_BITS = 2;

    localparam logic [REG_INDEX_BITS-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_WIDTH    = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } lrt_queue_status_t;

endpackage

@@ sv/lrt_front.sv @@
// ----------------------------------------------------------------------------
// lrt_front
// accepts line commands and step items, walks the line one pixel per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrt_front #(
    parameter int COORD_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [COORD_BITS-1:0]             window_x_offset,
    input  logic [COORD_BITS-1:0]             window_y_offset,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [COORD_BITS-1:0]             x_start,
    input  logic [COORD_BITS-1:0]             y_start,
    input  logic [COORD_BITS-1:0]             x_end,
    input  logic [COORD_BITS-1:0]             y_end,
    input  logic [lrt_pkg::THICK_BITS-1:0]    thickness,
    input  logic [lrt_pkg::COLOUR_BITS-1:0]   colour,
    input  lrt_pkg::lrt_queue_status_t        queue_status,
    output logic                              push,
    output logic signed [COORD_BITS+1:0]      push_x,
    output logic signed [COORD_BITS+1:0]      push_y,
    output logic [lrt_pkg::COLOUR_BITS-1:0]   push_colour,
    output logic                              push_last
);
    import lrt_pkg::*;

    localparam int CW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = CW + 1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_VERT = 2'd1;
    localparam logic [1:0] MODE_HORZ = 2'd2;
    localparam logic [1:0] MODE_DIAG = 2'd3;

    logic [1:0]             mode_reg, mode_next;
    logic signed [CW-1:0]   cur_x_reg, cur_x_next;
    logic signed [CW-1:0]   cur_y_reg, cur_y_next;
    logic signed [CW-1:0]   end_x_reg, end_x_next;
    logic signed [CW-1:0]   end_y_reg, end_y_next;
    logic [DW-1:0]          dx_reg, dx_next;
    logic [DW-1:0]          dy_reg, dy_next;
    logic                   sxn_reg, sxn_next;
    logic                   syn_reg, syn_next;
    logic signed [EW-1:0]   err_reg, err_next;
    logic [THICK_BITS-1:0]  wc_reg, wc_next;
    logic [THICK_BITS-1:0]  lw_reg, lw_next;
    logic [COLOUR_BITS-1:0] colour_reg, colour_next;

    logic                   accept;
    logic signed [CW-1:0]   xa, ya, xb, yb;
    logic signed [CW-1:0]   adx, ady;
    logic [DW-1:0]          ldx, ldy;
    logic signed [CW-1:0]   px, py;
    logic signed [CW-1:0]   wc_ext;
    logic                   vert, wrap, last;
    logic signed [EW-1:0]   dx_s, dy_s;
    logic                   cond_x, cond_y;

    assign in_ready = !queue_status.full;
    assign accept   = in_valid && in_ready;

    // window-local endpoints and spans of the incoming command
    always_comb
    begin
        xa  = $signed(CW'(x_start)) - $signed(CW'(window_x_offset));
        ya  = $signed(CW'(y_start)) - $signed(CW'(window_y_offset));
        xb  = $signed(CW'(x_end)) - $signed(CW'(window_x_offset));
        yb  = $signed(CW'(y_end)) - $signed(CW'(window_y_offset));
        adx = (xb > xa) ? (xb - xa) : (xa - xb);
        ady = (yb > ya) ? (yb - ya) : (ya - yb);
        ldx = adx[DW-1:0];
        ldy = ady[DW-1:0];
    end

    always_comb
    begin
        mode_next   = mode_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        end_x_next  = end_x_reg;
        end_y_next  = end_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sxn_next    = sxn_reg;
        syn_next    = syn_reg;
        err_next    = err_reg;
        wc_next     = wc_reg;
        lw_next     = lw_reg;
        colour_next = colour_reg;
        push        = 1'b0;
        px          = cur_x_reg;
        py          = cur_y_reg;
        last        = 1'b0;
        vert        = (mode_reg == MODE_VERT);
        wc_ext      = $signed(CW'(wc_reg));
        wrap        = ({1'b0, wc_reg} + 5'd1) >= {1'b0, lw_reg};
        dx_s        = $signed(EW'(dx_reg));
        dy_s        = $signed(EW'(dy_reg));
        cond_x      = err_reg > -dx_s;
        cond_y      = err_reg < dy_s;

        if (accept && !op)
        begin
            lw_next     = thickness;
            colour_next = colour;
            wc_next     = '0;
            dx_next     = ldx;
            dy_next     = ldy;
            sxn_next    = !(xa < xb);
            syn_next    = !(ya < yb);
            err_next    = (ldx > ldy) ? $signed(EW'(ldx >> 1)) : -$signed(EW'(ldy >> 1));
            if (ldx == '0)
            begin
                cur_x_next = xa;
                end_x_next = xa;
                cur_y_next = (ya < yb) ? ya : yb;
                end_y_next = (ya < yb) ? yb : ya;
                mode_next  = (thickness != '0) ? MODE_VERT : MODE_IDLE;
            end
            else if (ldy == '0)
            begin
                cur_y_next = ya;
                end_y_next = ya;
                cur_x_next = (xa < xb) ? xa : xb;
                end_x_next = (xa < xb) ? xb : xa;
                mode_next  = (thickness != '0) ? MODE_HORZ : MODE_IDLE;
            end
            else
            begin
                cur_x_next = xa;
                cur_y_next = ya;
                end_x_next = xb;
                end_y_next = yb;
                mode_next  = MODE_DIAG;
            end
        end
        else if (accept && op && mode_reg != MODE_IDLE)
        begin
            push = 1'b1;
            if (mode_reg == MODE_DIAG)
            begin
                last = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
                if (!last)
                begin
                    err_next = err_reg - (cond_x ? dy_s : '0) + (cond_y ? dx_s : '0);
                    if (cond_x)
                        cur_x_next = sxn_reg ? cur_x_reg - CW'(1) : cur_x_reg + CW'(1);
                    if (cond_y)
                        cur_y_next = syn_reg ? cur_y_reg - CW'(1) : cur_y_reg + CW'(1);
                end
            end
            else
            begin
                px   = vert ? cur_x_reg + wc_ext : cur_x_reg;
                py   = vert ? cur_y_reg : cur_y_reg + wc_ext;
                last = (vert ? (cur_y_reg == end_y_reg) : (cur_x_reg == end_x_reg)) && wrap;
                if (wrap)
                begin
                    wc_next = '0;
                    if (vert)
                        cur_y_next = cur_y_reg + CW'(1);
                    else
                        cur_x_next = cur_x_reg + CW'(1);
                end
                else
                begin
                    wc_next = wc_reg + THICK_BITS'(1);
                end
            end
            if (last)
                mode_next = MODE_IDLE;
        end
    end

    assign push_x      = px;
    assign push_y      = py;
    assign push_colour = colour_reg;
    assign push_last   = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            end_x_reg  <= '0;
            end_y_reg  <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            sxn_reg    <= 1'b0;
            syn_reg    <= 1'b0;
            err_reg    <= '0;
            wc_reg     <= '0;
            lw_reg     <= '0;
            colour_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            end_x_reg  <= end_x_next;
            end_y_reg  <= end_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            sxn_reg    <= sxn_next;
            syn_reg    <= syn_next;
            err_reg    <= err_next;
            wc_reg     <= wc_next;
            lw_reg     <= lw_next;
            colour_reg <= colour_next;
        end
    end

endmodule

@@ sv/lrt_fifo.sv @@
// ----------------------------------------------------------------------------
// lrt_fifo
// short pixel queue between the line walker and the address pipe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrt_fifo #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output lrt_pkg::lrt_queue_status_t status
);
    import lrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/lrt_back.sv @@
// ----------------------------------------------------------------------------
// lrt_back
// two-stage address pipe: row times stride, then column add and clipping
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrt_back #(
    parameter int COORD_BITS = 8,
    parameter int ADDR_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [COORD_BITS:0]               window_width,
    input  lrt_pkg::lrt_queue_status_t        queue_status,
    output logic                              pop,
    input  logic signed [COORD_BITS+1:0]      pop_x,
    input  logic signed [COORD_BITS+1:0]      pop_y,
    input  logic [lrt_pkg::COLOUR_BITS-1:0]   pop_colour,
    input  logic                              pop_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ADDR_BITS-1:0]              pixel_address,
    output logic [lrt_pkg::COLOUR_BITS-1:0]   pixel_colour,
    output logic                              outside_window,
    output logic                              last_pixel
);
    import lrt_pkg::*;

    localparam int CW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = (PW + 1 > ADDR_BITS + 1) ? PW + 1 : ADDR_BITS + 1;

    logic                   a_valid_reg, a_valid_next;
    logic [PW-1:0]          a_prod_reg;
    logic [DW-1:0]          a_px_reg;
    logic                   a_out_reg;
    logic [COLOUR_BITS-1:0] a_colour_reg;
    logic                   a_last_reg;

    logic                   b_valid_reg, b_valid_next;
    logic [ADDR_BITS-1:0]   b_addr_reg;
    logic [COLOUR_BITS-1:0] b_colour_reg;
    logic                   b_out_reg;
    logic                   b_last_reg;

    logic                   en_a, en_b;
    logic [DW-1:0]          px_u, py_u;
    logic                   clip_a;
    logic [SW-1:0]          sum;
    logic                   clip_b;

    assign en_b = !b_valid_reg || out_ready;
    assign en_a = !a_valid_reg || en_b;
    assign pop  = en_a && !queue_status.empty;

    always_comb
    begin
        px_u   = pop_x[DW-1:0];
        py_u   = pop_y[DW-1:0];
        clip_a = pop_x[CW-1] || pop_y[CW-1] || (px_u >= window_width);
        sum    = SW'(a_prod_reg) + SW'(a_px_reg);
        clip_b = a_out_reg || (sum[SW-1:ADDR_BITS] != '0);
    end

    assign a_valid_next = en_a ? pop : a_valid_reg;
    assign b_valid_next = en_b ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_prod_reg   <= py_u * window_width;
            a_px_reg     <= px_u;
            a_out_reg    <= clip_a;
            a_colour_reg <= pop_colour;
            a_last_reg   <= pop_last;
        end
        if (en_b && a_valid_reg)
        begin
            b_addr_reg   <= clip_b ? '0 : sum[ADDR_BITS-1:0];
            b_out_reg    <= clip_b;
            b_colour_reg <= a_colour_reg;
            b_last_reg   <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    assign out_valid      = b_valid_reg;
    assign pixel_address  = b_addr_reg;
    assign pixel_colour   = b_colour_reg;
    assign outside_window = b_out_reg;
    assign last_pixel     = b_last_reg;

endmodule

@@ sv/line_raster_with_thickness_core.sv @@
// one step transfer in per cycle while the queue has room, one pixel write out per
// cycle when not stalled; a pixel write passes the queue and both back-end stages
// before it is offered; input stalls only while the four-entry queue is full
// the walker updates its position in the cycle of the transfer; the back end
// is a multiply stage and an add-and-clip stage behind the queue
// reset is asynchronous: walker idle, queue empty, window registers 0, 0 and
// half the coordinate range (128 at eight bits)
`timescale 1ns / 1ps

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// line_raster_with_thickness_core
// line rasterizer producing frame buffer pixel writes with window clipping
// ----------------------------------------------------------------------------
module line_raster_with_thickness_core #(
    parameter int COORD_BITS = 8,
    parameter int ADDR_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lrt_pkg::REG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS:0]                  cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [COORD_BITS-1:0]                x_start,
    input  logic [COORD_BITS-1:0]                y_start,
    input  logic [COORD_BITS-1:0]                x_end,
    input  logic [COORD_BITS-1:0]                y_end,
    input  logic [lrt_pkg::THICK_BITS-1:0]       thickness,
    input  logic [lrt_pkg::COLOUR_BITS-1:0]      colour,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ADDR_BITS-1:0]                 pixel_address,
    output logic [lrt_pkg::COLOUR_BITS-1:0]      pixel_colour,
    output logic                                 outside_window,
    output logic                                 last_pixel
);
    import lrt_pkg::*;

    localparam int CW          = COORD_BITS + 2;
    localparam int QUEUE_WIDTH = 2 * CW + COLOUR_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [COORD_BITS:0] WIDTH_RESET = (COORD_BITS+1)'(1) << (COORD_BITS - 1);

    logic [COORD_BITS-1:0]  x_off_reg, x_off_next;
    logic [COORD_BITS-1:0]  y_off_reg, y_off_next;
    logic [COORD_BITS:0]    width_reg, width_next;

    lrt_queue_status_t      queue_status;
    logic                   push, pop;
    logic signed [CW-1:0]   push_x, push_y, pop_x, pop_y;
    logic [COLOUR_BITS-1:0] push_colour, pop_colour;
    logic                   push_last, pop_last;
    logic [QUEUE_WIDTH-1:0] push_data, pop_data;

    always_comb
    begin
        x_off_next = x_off_reg;
        y_off_next = y_off_reg;
        width_next = width_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: x_off_next = cfg_wdata[COORD_BITS-1:0];
                REG_Y_OFFSET: y_off_next = cfg_wdata[COORD_BITS-1:0];
                REG_WIDTH:    width_next = cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= '0;
            y_off_reg <= '0;
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            x_off_reg <= x_off_next;
            y_off_reg <= y_off_next;
            width_reg <= width_next;
        end
    end

    lrt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_x_offset (x_off_reg),
        .window_y_offset (y_off_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .x_start         (x_start),
        .y_start         (y_start),
        .x_end           (x_end),
        .y_end           (y_end),
        .thickness       (thickness),
        .colour          (colour),
        .queue_status    (queue_status),
        .push            (push),
        .push_x          (push_x),
        .push_y          (push_y),
        .push_colour     (push_colour),
        .push_last       (push_last)
    );

    assign push_data = {push_x, push_y, push_colour, push_last};
    assign {pop_x, pop_y, pop_colour, pop_last} = pop_data;

    lrt_fifo #(
        .WIDTH (QUEUE_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (queue_status)
    );

    lrt_back #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_width   (width_reg),
        .queue_status   (queue_status),
        .pop            (pop),
        .pop_x          (pop_x),
        .pop_y          (pop_y),
        .pop_colour     (pop_colour),
        .pop_last       (pop_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_address  (pixel_address),
        .pixel_colour   (pixel_colour),
        .outside_window (outside_window),
        .last_pixel     (last_pixel)
    );

    `LRT_ASSERT_NEVER(a_queue_status, queue_status.full && queue_status.empty, "queue full and empty")
    `LRT_ASSERT(a_push_on_transfer, push |-> (in_valid && in_ready && op), "push without step transfer")
    `LRT_ASSERT(a_load_no_push, (in_valid && in_ready && !op) |-> !push, "load transfer pushed a pixel")
    `LRT_ASSERT(a_clip_zero_addr, (out_valid && outside_window) |-> (pixel_address == '0), "clipped pixel has address")

endmodule
